// File: rtl/xdb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xdb_pkg
// Shared types and constants of the XOR distance bucket table.
// ----------------------------------------------------------------------------
package xdb_pkg;

   localparam int IdBits       = 32;
   localparam int InfoBits     = 48;
   localparam int BucketDepth  = 8;
   localparam int ClosestCount = 5;
   localparam int NumSlots     = IdBits * BucketDepth;
   localparam int BktW         = $clog2(IdBits);
   localparam int PosW         = $clog2(BucketDepth);
   localparam int FillW        = $clog2(BucketDepth + 1);
   localparam int SlotW        = $clog2(NumSlots);
   localparam int KW           = $clog2(ClosestCount + 1);

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_FIND   = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_INSERTED  = 4'd0,
      ST_DUPLICATE = 4'd1,
      ST_FULL      = 4'd2,
      ST_REMOVED   = 4'd3,
      ST_ABSENT    = 4'd4,
      ST_SELF      = 4'd5,
      ST_EXACT     = 4'd6,
      ST_BUCKET    = 4'd7,
      ST_CLOSEST   = 4'd8,
      ST_EMPTY     = 4'd9
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             load;      // capture request, compute bucket
      logic             rd_en;     // read memory at rd_addr
      logic [SlotW-1:0] rd_addr;
      logic             wr_new;    // write captured id/info at wr_addr
      logic             wr_copy;   // write last read data at wr_addr
      logic [SlotW-1:0] wr_addr;
      logic             fill_inc;
      logic             fill_dec;
      logic             best_clr;  // start of a closest scan pass
      logic             best_upd;  // compare the read slot with the best
      logic             prev_set;  // best becomes previous
      logic             out_rd;    // result comes from read data
      logic             out_best;  // result comes from best register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic             self_hit;
      logic [BktW-1:0]  bkt;
      logic [FillW-1:0] fill;      // fill of the request bucket
      logic             rd_match;  // last read id equals request id
      logic             found;     // best register holds a candidate
      logic             more;      // a farther distinct candidate was seen
   } stat_type;

endpackage
`default_nettype wire

// File: rtl/xdb_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xdb_datapath
// Slot memories, bucket fill counts, bucket choice and nearest search.
// ----------------------------------------------------------------------------
module xdb_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [xdb_pkg::IdBits-1:0]     own_id,
   input  wire logic [xdb_pkg::IdBits-1:0]     req_node_id,
   input  wire logic [xdb_pkg::InfoBits-1:0]   req_node_info,
   input  wire xdb_pkg::cmd_type               cmd,
   output xdb_pkg::stat_type                   stat,
   output logic [xdb_pkg::IdBits-1:0]          out_id,
   output logic [xdb_pkg::InfoBits-1:0]        out_info
);

   logic [xdb_pkg::IdBits-1:0]   id_mem [xdb_pkg::NumSlots];
   logic [xdb_pkg::InfoBits-1:0] info_mem [xdb_pkg::NumSlots];
   logic [xdb_pkg::FillW-1:0]    fill_ff [xdb_pkg::IdBits];

   logic [xdb_pkg::IdBits-1:0]   id_ff;
   logic [xdb_pkg::InfoBits-1:0] info_ff;
   logic [xdb_pkg::BktW-1:0]     bkt_ff;
   logic                         self_ff;
   logic [xdb_pkg::IdBits-1:0]   rd_id_ff;
   logic [xdb_pkg::InfoBits-1:0] rd_info_ff;
   logic                         rd_vld_ff;
   logic                         rd_live_ff;
   logic [xdb_pkg::IdBits-1:0]   best_d_ff;
   logic [xdb_pkg::IdBits-1:0]   best_id_ff;
   logic [xdb_pkg::InfoBits-1:0] best_info_ff;
   logic                         found_ff;
   logic                         more_ff;
   logic [xdb_pkg::IdBits-1:0]   prev_ff;
   logic                         have_prev_ff;

   logic [xdb_pkg::IdBits-1:0]   diff;
   logic [xdb_pkg::BktW-1:0]     bkt_in;
   logic [xdb_pkg::IdBits-1:0]   cand_d;
   logic                         cand_new;
   logic                         cand_ok;
   logic                         take;
   logic                         more_hit;
   logic [xdb_pkg::SlotW-1:0]    wr_slot;

   always_comb begin
      diff   = own_id ^ req_node_id;
      bkt_in = '0;
      for (int b = 0; b < xdb_pkg::IdBits; b++) begin
         if (diff[b]) begin
            bkt_in = xdb_pkg::BktW'(xdb_pkg::IdBits - 1 - b);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff   <= req_node_id;
         info_ff <= req_node_info;
         bkt_ff  <= bkt_in;
         self_ff <= (diff == '0);
      end
   end

   assign wr_slot = cmd.wr_addr;

   always_ff @(posedge clock) begin
      if (cmd.wr_new) begin
         id_mem[wr_slot]   <= id_ff;
         info_mem[wr_slot] <= info_ff;
      end else if (cmd.wr_copy) begin
         id_mem[wr_slot]   <= rd_id_ff;
         info_mem[wr_slot] <= rd_info_ff;
      end
      if (cmd.rd_en) begin
         rd_id_ff   <= id_mem[cmd.rd_addr];
         rd_info_ff <= info_mem[cmd.rd_addr];
         rd_live_ff <= (xdb_pkg::FillW'(cmd.rd_addr[xdb_pkg::PosW-1:0]) <
                        fill_ff[cmd.rd_addr[xdb_pkg::SlotW-1:xdb_pkg::PosW]]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < xdb_pkg::IdBits; b++) begin
            fill_ff[b] <= '0;
         end
      end else if (cmd.fill_inc) begin
         fill_ff[bkt_ff] <= fill_ff[bkt_ff] + 1'b1;
      end else if (cmd.fill_dec) begin
         fill_ff[bkt_ff] <= fill_ff[bkt_ff] - 1'b1;
      end
   end

   assign cand_d   = rd_id_ff ^ id_ff;
   assign cand_new = !(have_prev_ff && cand_d <= prev_ff);
   assign cand_ok  = cand_new && (!found_ff || cand_d < best_d_ff);
   assign take     = cmd.best_upd && rd_live_ff && cand_ok;
   assign more_hit = cmd.best_upd && rd_live_ff && cand_new && found_ff &&
                     (cand_d != best_d_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff     <= 1'b0;
         more_ff      <= 1'b0;
         have_prev_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            have_prev_ff <= 1'b0;
         end else if (cmd.prev_set) begin
            have_prev_ff <= 1'b1;
         end
         if (cmd.best_clr) begin
            found_ff <= 1'b0;
         end else if (take) begin
            found_ff <= 1'b1;
         end
         if (cmd.best_clr) begin
            more_ff <= 1'b0;
         end else if (more_hit) begin
            more_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_d_ff    <= cand_d;
         best_id_ff   <= rd_id_ff;
         best_info_ff <= rd_info_ff;
      end
      if (cmd.prev_set) begin
         prev_ff <= best_d_ff;
      end
   end

   always_comb begin
      stat.self_hit  = self_ff;
      stat.bkt       = bkt_ff;
      stat.fill      = fill_ff[bkt_ff];
      stat.rd_match  = rd_vld_ff && (rd_id_ff == id_ff);
      stat.found     = found_ff;
      stat.more      = more_ff;
      out_id         = '0;
      out_info       = '0;
      if (cmd.out_rd) begin
         out_id   = rd_id_ff;
         out_info = rd_info_ff;
      end else if (cmd.out_best) begin
         out_id   = best_id_ff;
         out_info = best_info_ff;
      end
   end

endmodule
`default_nettype wire

// File: rtl/xdb_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xdb_controller
// Sequencer for insert, remove and find over the slot memory.
// ----------------------------------------------------------------------------
module xdb_controller (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [1:0]                req_func,
   output logic                           busy,
   input  wire xdb_pkg::stat_type         stat,
   output xdb_pkg::cmd_type               cmd,
   output logic                           rsp_strobe,
   output logic [3:0]                     rsp_status,
   output logic                           rsp_last
);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_DECODE = 10'b0000000010,
      S_LOCATE = 10'b0000000100,
      S_WAIT   = 10'b0000001000,
      S_SHIFT  = 10'b0000010000,
      S_BUCKET = 10'b0000100000,
      S_SCAN   = 10'b0001000000,
      S_SDRAIN = 10'b0010000000,
      S_EMIT   = 10'b0100000000,
      S_RESP   = 10'b1000000000
   } state_type;

   state_type                     state_ff, state_in;
   xdb_pkg::func_type             func_ff, func_in;
   logic [xdb_pkg::PosW:0]        pos_ff, pos_in;
   logic [xdb_pkg::SlotW:0]       scan_ff, scan_in;
   logic [xdb_pkg::KW-1:0]        k_ff, k_in;
   logic [3:0]                    st_ff, st_in;
   logic                          lastv_ff, lastv_in;
   logic                          hit_ff, hit_in;
   logic [xdb_pkg::PosW-1:0]      hitpos_ff, hitpos_in;
   logic [xdb_pkg::SlotW-1:0]     base;
   logic [xdb_pkg::PosW-1:0]      pidx;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         func_ff   <= xdb_pkg::FUNC_NONE;
         pos_ff    <= '0;
         scan_ff   <= '0;
         k_ff      <= '0;
         st_ff     <= '0;
         lastv_ff  <= 1'b0;
         hit_ff    <= 1'b0;
         hitpos_ff <= '0;
      end else begin
         state_ff  <= state_in;
         func_ff   <= func_in;
         pos_ff    <= pos_in;
         scan_ff   <= scan_in;
         k_ff      <= k_in;
         st_ff     <= st_in;
         lastv_ff  <= lastv_in;
         hit_ff    <= hit_in;
         hitpos_ff <= hitpos_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign base      = xdb_pkg::SlotW'({stat.bkt, {xdb_pkg::PosW{1'b0}}});
   assign pidx      = pos_ff[xdb_pkg::PosW-1:0];

   always_comb begin
      state_in   = state_ff;
      func_in    = func_ff;
      pos_in     = pos_ff;
      scan_in    = scan_ff;
      k_in       = k_ff;
      st_in      = st_ff;
      lastv_in   = lastv_ff;
      hit_in     = hit_ff;
      hitpos_in  = hitpos_ff;
      cmd        = '0;
      rsp_strobe = 1'b0;
      rsp_status = st_ff;
      rsp_last   = lastv_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               func_in  = xdb_pkg::func_type'(req_func);
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            pos_in = '0;
            hit_in = 1'b0;
            if (func_ff == xdb_pkg::FUNC_NONE) begin
               state_in = S_IDLE;
            end else if (stat.self_hit) begin
               st_in    = xdb_pkg::ST_SELF;
               state_in = S_RESP;
            end else if (func_ff == xdb_pkg::FUNC_INSERT &&
                         stat.fill >= xdb_pkg::FillW'(xdb_pkg::BucketDepth)) begin
               st_in    = xdb_pkg::ST_FULL;
               state_in = S_RESP;
            end else begin
               state_in = S_LOCATE;
            end
         end
         S_LOCATE: begin
            // Issue a read of position pos; the match of the previous read is checked.
            if (stat.rd_match && !hit_ff) begin
               hit_in    = 1'b1;
               hitpos_in = pidx - 1'b1;
            end
            if (xdb_pkg::FillW'(pos_ff) < stat.fill && !(stat.rd_match || hit_ff)) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = base | xdb_pkg::SlotW'(pidx);
               pos_in      = pos_ff + 1'b1;
            end else begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (stat.rd_match && !hit_ff) begin
               hit_in    = 1'b1;
               hitpos_in = pidx - 1'b1;
            end
            if (hit_ff || stat.rd_match) begin
               unique case (func_ff)
                  xdb_pkg::FUNC_INSERT: begin
                     st_in    = xdb_pkg::ST_DUPLICATE;
                     state_in = S_RESP;
                  end
                  xdb_pkg::FUNC_REMOVE: begin
                     pos_in   = {1'b0, (hit_ff ? hitpos_ff : pidx - 1'b1)};
                     state_in = S_SHIFT;
                  end
                  default: begin
                     // Read data still holds the matched slot.
                     st_in    = xdb_pkg::ST_EXACT;
                     lastv_in = 1'b1;
                     state_in = S_EMIT;
                  end
               endcase
            end else begin
               unique case (func_ff)
                  xdb_pkg::FUNC_INSERT: begin
                     cmd.wr_new   = 1'b1;
                     cmd.wr_addr  = base | xdb_pkg::SlotW'(stat.fill);
                     cmd.fill_inc = 1'b1;
                     st_in        = xdb_pkg::ST_INSERTED;
                     state_in     = S_RESP;
                  end
                  xdb_pkg::FUNC_REMOVE: begin
                     st_in    = xdb_pkg::ST_ABSENT;
                     state_in = S_RESP;
                  end
                  default: begin
                     if (stat.fill > xdb_pkg::FillW'(1)) begin
                        pos_in   = '0;
                        state_in = S_BUCKET;
                     end else begin
                        scan_in  = '0;
                        k_in     = '0;
                        state_in = S_SCAN;
                     end
                  end
               endcase
            end
         end
         S_SHIFT: begin
            // Each move reads slot pos+1, then writes it to pos.
            if (hit_ff) begin
               if (xdb_pkg::FillW'(pos_ff) + 1'b1 < stat.fill) begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_addr = base | xdb_pkg::SlotW'(pidx + 1'b1);
                  hit_in      = 1'b0;
               end else begin
                  cmd.fill_dec = 1'b1;
                  st_in        = xdb_pkg::ST_REMOVED;
                  state_in     = S_RESP;
               end
            end else begin
               cmd.wr_copy = 1'b1;
               cmd.wr_addr = base | xdb_pkg::SlotW'(pidx);
               pos_in      = pos_ff + 1'b1;
               hit_in      = 1'b1;
            end
         end
         S_BUCKET: begin
            // Read issued with hit low; emitted the next cycle with hit high.
            if (hit_ff) begin
               rsp_strobe = 1'b1;
               rsp_status = xdb_pkg::ST_BUCKET;
               cmd.out_rd = 1'b1;
               rsp_last   = (xdb_pkg::FillW'(pos_ff) >= stat.fill);
               hit_in     = 1'b0;
               if (rsp_last) begin
                  state_in = S_IDLE;
               end
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = base | xdb_pkg::SlotW'(pidx);
               pos_in      = pos_ff + 1'b1;
               hit_in      = 1'b1;
            end
         end
         S_SCAN: begin
            if (scan_ff == '0) begin
               cmd.best_clr = 1'b1;
            end
            cmd.best_upd = (scan_ff != '0) && hit_ff;
            cmd.rd_addr  = scan_ff[xdb_pkg::SlotW-1:0];
            cmd.rd_en    = !scan_ff[xdb_pkg::SlotW];
            hit_in       = cmd.rd_en;
            if (scan_ff[xdb_pkg::SlotW]) begin
               state_in = S_SDRAIN;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_SDRAIN: begin
            cmd.best_upd = hit_ff;
            hit_in       = 1'b0;
            state_in     = S_EMIT;
            st_in        = xdb_pkg::ST_CLOSEST;
         end
         S_EMIT: begin
            rsp_strobe = 1'b1;
            if (st_ff == xdb_pkg::ST_EXACT) begin
               cmd.out_rd = 1'b1;
               rsp_last   = 1'b1;
               state_in   = S_IDLE;
               lastv_in   = 1'b0;
            end else if (stat.found) begin
               cmd.out_best = 1'b1;
               cmd.prev_set = 1'b1;
               rsp_status   = xdb_pkg::ST_CLOSEST;
               k_in         = k_ff + 1'b1;
               rsp_last     = (k_ff == xdb_pkg::KW'(xdb_pkg::ClosestCount - 1)) ||
                              !stat.more;
               scan_in      = '0;
               state_in     = rsp_last ? S_IDLE : S_SCAN;
            end else begin
               // No candidate at all: the table is empty.
               rsp_status = xdb_pkg::ST_EMPTY;
               rsp_last   = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_RESP: begin
            rsp_strobe = 1'b1;
            rsp_last   = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: rtl/xor_distance_bucket_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xor_distance_bucket_table
// Peer routing table with XOR distance buckets, insert, remove and find.
//
//  channel | ports                          | handshake
//  request | req_func, req_node_id, _info   | start, busy
//  result  | rsp_status, _entry_id, _info,  | rsp_strobe, one cycle
//          | rsp_last                       |
//  csr     | csr_wdata                      | csr_valid, csr_ready
//
// Insert and remove are bounded by the walk over the request bucket. A bucket
// find reads and then emits each entry of the bucket in turn. A closest find
// runs one full scan of the 256-slot memory per result through the single read
// port. Reset clears the fill counts. Results cannot be stalled; the next
// request is taken once busy falls.
// ----------------------------------------------------------------------------
module xor_distance_bucket_table (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_func,
   input  wire logic [xdb_pkg::IdBits-1:0]    req_node_id,
   input  wire logic [xdb_pkg::InfoBits-1:0]  req_node_info,
   output logic                               rsp_strobe,
   output logic [3:0]                         rsp_status,
   output logic [xdb_pkg::IdBits-1:0]         rsp_entry_id,
   output logic [xdb_pkg::InfoBits-1:0]       rsp_entry_info,
   output logic                               rsp_last,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [xdb_pkg::IdBits-1:0]    csr_wdata
);

   logic [xdb_pkg::IdBits-1:0] own_id_ff;
   xdb_pkg::cmd_type           cmd;
   xdb_pkg::stat_type          stat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         own_id_ff <= csr_wdata;
      end
   end

   xdb_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_func   (req_func),
      .busy       (busy),
      .stat       (stat),
      .cmd        (cmd),
      .rsp_strobe (rsp_strobe),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_last)
   );

   xdb_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .own_id        (own_id_ff),
      .req_node_id   (req_node_id),
      .req_node_info (req_node_info),
      .cmd           (cmd),
      .stat          (stat),
      .out_id        (rsp_entry_id),
      .out_info      (rsp_entry_info)
   );

`ifndef SYNTH
   a_no_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !rsp_strobe) else $error("result while idle");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !busy) else $error("busy after last result");
   a_wr_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_new && cmd.wr_copy)) else $error("two memory writes");
`endif

endmodule
`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the XOR distance bucket table. Directed requests
// cover the own id, full and duplicate buckets, removal, empty lookups and
// every find outcome. Random requests then follow under several own ids and
// idle patterns. A scoreboard mirrors the table and checks every result.
// ----------------------------------------------------------------------------
module tb_top;

   typedef struct {
      xdb_pkg::status_type status;
      logic [31:0]         id;
      logic [47:0]         info;
      logic                last;
   } result_type;

   class table_scoreboard;
      logic [31:0] own_id;
      logic [31:0] slot_id [32][8];
      logic [47:0] slot_info [32][8];
      int          fill [32];
      result_type  pending [$];
      int          errors;

      function new();
         own_id = '0;
         errors = 0;
         foreach (fill[b]) fill[b] = 0;
      endfunction

      function int bucket_of(logic [31:0] id);
         logic [31:0] diff;
         int          n;
         diff = own_id ^ id;
         n = 0;
         if (diff == 0) return -1;
         for (int b = 31; b >= 0; b--) begin
            if (diff[b]) break;
            n++;
         end
         return n;
      endfunction

      function int locate(int bk, logic [31:0] id);
         for (int i = 0; i < fill[bk]; i++)
            if (slot_id[bk][i] == id) return i;
         return -1;
      endfunction

      function void push(xdb_pkg::status_type st, logic [31:0] id, logic [47:0] info);
         result_type r;
         r.status = st;
         r.id = id;
         r.info = info;
         r.last = 1'b0;
         pending.insert(pending.size(), r);
      endfunction

      function void note_request(xdb_pkg::func_type func, logic [31:0] id,
                                 logic [47:0] info);
         int          bk;
         int          pos;
         int          n;
         logic [31:0] prev;
         logic [31:0] best;
         logic [31:0] d;
         int          best_b;
         int          best_i;
         bit          have_prev;
         bit          found;
         if (func == xdb_pkg::FUNC_NONE) return;
         bk = bucket_of(id);
         n = 1;
         if (bk < 0) begin
            push(xdb_pkg::ST_SELF, '0, '0);
         end else if (func == xdb_pkg::FUNC_INSERT) begin
            if (fill[bk] >= 8) begin
               push(xdb_pkg::ST_FULL, '0, '0);
            end else if (locate(bk, id) >= 0) begin
               push(xdb_pkg::ST_DUPLICATE, '0, '0);
            end else begin
               slot_id[bk][fill[bk]] = id;
               slot_info[bk][fill[bk]] = info;
               fill[bk]++;
               push(xdb_pkg::ST_INSERTED, '0, '0);
            end
         end else if (func == xdb_pkg::FUNC_REMOVE) begin
            pos = locate(bk, id);
            if (pos < 0) begin
               push(xdb_pkg::ST_ABSENT, '0, '0);
            end else begin
               for (int i = pos; i + 1 < fill[bk]; i++) begin
                  slot_id[bk][i] = slot_id[bk][i + 1];
                  slot_info[bk][i] = slot_info[bk][i + 1];
               end
               fill[bk]--;
               push(xdb_pkg::ST_REMOVED, '0, '0);
            end
         end else begin
            pos = locate(bk, id);
            if (pos >= 0) begin
               push(xdb_pkg::ST_EXACT, slot_id[bk][pos], slot_info[bk][pos]);
            end else if (fill[bk] > 1) begin
               for (int i = 0; i < fill[bk]; i++)
                  push(xdb_pkg::ST_BUCKET, slot_id[bk][i], slot_info[bk][i]);
            end else begin
               n = 0;
               have_prev = 0;
               prev = '0;
               for (int k = 0; k < xdb_pkg::ClosestCount; k++) begin
                  found = 0;
                  best = '0;
                  best_b = 0;
                  best_i = 0;
                  for (int b = 0; b < 32; b++)
                     for (int i = 0; i < fill[b]; i++) begin
                        d = slot_id[b][i] ^ id;
                        if (have_prev && d <= prev) continue;
                        if (!found || d < best) begin
                           found = 1;
                           best = d;
                           best_b = b;
                           best_i = i;
                        end
                     end
                  if (!found) break;
                  push(xdb_pkg::ST_CLOSEST, slot_id[best_b][best_i],
                       slot_info[best_b][best_i]);
                  n++;
                  prev = best;
                  have_prev = 1;
               end
               if (n == 0) push(xdb_pkg::ST_EMPTY, '0, '0);
            end
         end
         pending[pending.size() - 1].last = 1'b1;
      endfunction

      function void check_result(logic [3:0] st, logic [31:0] id, logic [47:0] info,
                                 logic last);
         result_type e;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: status %0d id %h info %h last %b",
                        st, id, info, last);
            return;
         end
         e = pending.pop_front();
         if (st !== e.status || id !== e.id || info !== e.info || last !== e.last) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected %0d %h %h %b, got %0d %h %h %b",
                        e.status, e.id, e.info, e.last, st, id, info, last);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_func = '0;
   logic [31:0] req_node_id = '0;
   logic [47:0] req_node_info = '0;
   logic        rsp_strobe;
   logic [3:0]  rsp_status;
   logic [31:0] rsp_entry_id;
   logic [47:0] rsp_entry_info;
   logic        rsp_last;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [31:0] csr_wdata = '0;

   table_scoreboard scoreboard = new();
   int unsigned     cycles = 0;
   int              idle_pct = 0;
   logic [31:0]     tail_pool [12];

   xor_distance_bucket_table dut (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("xor_distance_bucket_table test failed");
         $finish;
      end
      if (!reset && rsp_strobe)
         scoreboard.check_result(rsp_status, rsp_entry_id, rsp_entry_info, rsp_last);
   end

   task automatic send_request(xdb_pkg::func_type func, logic [31:0] id,
                               logic [47:0] info);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_func <= func;
      req_node_id <= id;
      req_node_info <= info;
      do @(posedge clock); while (busy);
      scoreboard.note_request(func, id, info);
   endtask

   task automatic write_own_id(logic [31:0] value);
      start <= 1'b0;
      while (scoreboard.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      scoreboard.own_id = value;
   endtask

   function automatic logic [47:0] random_info();
      return {16'($urandom), $urandom};
   endfunction

   function automatic logic [31:0] near_id(int bk);
      logic [31:0] low_mask;
      low_mask = (bk == 31) ? 32'h0 : (32'hFFFF_FFFF >> (bk + 1));
      return scoreboard.own_id ^ (32'h8000_0000 >> bk) ^
             (tail_pool[$urandom_range(11)] & low_mask);
   endfunction

   function automatic logic [31:0] random_id();
      int pick;
      pick = $urandom_range(99);
      if (pick < 80) return near_id($urandom_range(3));
      if (pick < 90) return near_id($urandom_range(31));
      if (pick < 93) return scoreboard.own_id;
      return $urandom;
   endfunction

   function automatic xdb_pkg::func_type random_func();
      int pick;
      pick = $urandom_range(99);
      if (pick < 45) return xdb_pkg::FUNC_INSERT;
      if (pick < 65) return xdb_pkg::FUNC_REMOVE;
      if (pick < 95) return xdb_pkg::FUNC_FIND;
      return xdb_pkg::FUNC_NONE;
   endfunction

   initial begin
      logic [31:0] own_ids [4];
      int          idle_set [4];
      foreach (tail_pool[i]) tail_pool[i] = $urandom;
      own_ids = '{32'h0, 32'hFFFF_FFFF, $urandom, $urandom};
      idle_set = '{0, 74, 0, 22};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(xdb_pkg::FUNC_FIND, 32'h1234_5678, 48'h0);
      send_request(xdb_pkg::FUNC_INSERT, 32'h0, 48'hFFFF_FFFF_FFFF);
      send_request(xdb_pkg::FUNC_REMOVE, 32'h0, 48'h0);
      send_request(xdb_pkg::FUNC_FIND, 32'h0, 48'h0);
      for (int i = 0; i < 8; i++)
         send_request(xdb_pkg::FUNC_INSERT,
                      32'h8000_0000 | (i * 32'h1111_1111 & 32'h7FFF_FFFF),
                      random_info());
      send_request(xdb_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 48'h0);
      send_request(xdb_pkg::FUNC_INSERT, 32'h8000_0000, 48'h0);
      send_request(xdb_pkg::FUNC_REMOVE, 32'h9111_1111, 48'h0);
      send_request(xdb_pkg::FUNC_REMOVE, 32'h9111_1111, 48'h0);
      send_request(xdb_pkg::FUNC_INSERT, 32'h8000_0000, 48'h0);
      send_request(xdb_pkg::FUNC_FIND, 32'hA222_2222, 48'h0);
      send_request(xdb_pkg::FUNC_FIND, 32'hFFFF_FFFF, 48'h0);
      send_request(xdb_pkg::FUNC_INSERT, 32'h0000_0001, 48'hFFFF_FFFF_FFFF);
      send_request(xdb_pkg::FUNC_FIND, 32'h0000_0003, 48'h0);
      send_request(xdb_pkg::FUNC_FIND, 32'h4000_0000, 48'h0);
      send_request(xdb_pkg::FUNC_NONE, 32'h8000_0000, 48'h0);
      send_request(xdb_pkg::FUNC_FIND, 32'h0000_0001, 48'h0);

      for (int phase = 0; phase < 4; phase++) begin
         write_own_id(own_ids[phase]);
         idle_pct = idle_set[phase];
         for (int n = 0; n < 55; n++) begin
            if (n == 25) idle_pct = 0;
            if (n == 40) idle_pct = idle_set[phase];
            send_request(random_func(), random_id(), random_info());
         end
      end

      start <= 1'b0;
      while (scoreboard.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (scoreboard.errors == 0)
         $display("xor_distance_bucket_table test passed");
      else
         $display("xor_distance_bucket_table test failed");
      $finish;
   end

endmodule
